/* rtl/ffpa_pkg.sv */
`default_nettype none
package ffpa_pkg;

   localparam int MAX_PAGES  = 1024;
   localparam int PAGE_SHIFT = 12;
   localparam int REF_BITS   = 16;

   localparam int IDX_W  = $clog2(MAX_PAGES);
   localparam int PTR_W  = IDX_W + 1;
   localparam int CNT_W  = 11;
   localparam int ADDR_W = 32;

   localparam logic [PTR_W-1:0]    NULL_PTR  = PTR_W'(MAX_PAGES);
   localparam logic [REF_BITS-1:0] REF_MAX   = '1;
   localparam logic [ADDR_W-1:0]   PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_SHARE = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOFIT    = 3'd1;
   localparam logic [2:0] ST_MISALIGN = 3'd2;
   localparam logic [2:0] ST_BELOW    = 3'd3;
   localparam logic [2:0] ST_ABOVE    = 3'd4;
   localparam logic [2:0] ST_FREE     = 3'd5;

   localparam logic REG_BASE = 1'b0;
   localparam logic REG_NUM  = 1'b1;

   typedef struct packed {
      logic [1:0]        op;
      logic [CNT_W-1:0]  page_count;
      logic [ADDR_W-1:0] phys_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] result_addr;
      logic              in_range;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]    len;
      logic [REF_BITS-1:0] refc;
      logic [PTR_W-1:0]    next;
      logic [PTR_W-1:0]    prev;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [ADDR_W-1:0] base_addr;
      logic [CNT_W-1:0]  num_pages;
      logic              reinit;
   } cfg_type;

   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      entry_type          wr_data;
   } mem_req_type;

endpackage
`default_nettype wire

/* rtl/ffpa_ram.sv */
`default_nettype none
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* rtl/ffpa_csr.sv */
`default_nettype none
module ffpa_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic      [31:0]         prdata,
   output logic                     pready,
   output ffpa_pkg::cfg_type        cfg
);
   logic [ffpa_pkg::ADDR_W-1:0] base_ff;
   logic [ffpa_pkg::CNT_W-1:0]  num_ff;
   logic [ffpa_pkg::CNT_W-1:0]  num_in;
   logic                        wr_stb;

   assign pready = 1'b1;
   assign wr_stb = psel & penable & pwrite;

   always_comb begin
      num_in = pwdata[ffpa_pkg::CNT_W-1:0];
      if (num_in == '0) begin
         num_in = ffpa_pkg::CNT_W'(1);
      end else if (32'(num_in) > ffpa_pkg::MAX_PAGES) begin
         num_in = ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PAGES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         num_ff  <= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PAGES);
      end else if (wr_stb) begin
         unique case (paddr[2])
            ffpa_pkg::REG_BASE: base_ff <= pwdata & ~ffpa_pkg::PAGE_MASK;
            ffpa_pkg::REG_NUM:  num_ff  <= num_in;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ffpa_pkg::REG_BASE: prdata = base_ff;
         ffpa_pkg::REG_NUM:  prdata = 32'(num_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.base_addr = base_ff;
   assign cfg.num_pages = num_ff;
   assign cfg.reinit    = wr_stb;
endmodule
`default_nettype wire

/* rtl/ffpa_engine.sv */
`default_nettype none
module ffpa_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffpa_pkg::cfg_type    cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ffpa_pkg::req_type    req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ffpa_pkg::rsp_type         rsp_data,
   output ffpa_pkg::mem_req_type     mem,
   input  wire ffpa_pkg::entry_type  q
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_A_CUR, S_F_RD, S_F_CHK,
      S_M_NRD, S_M_NCHK, S_M_P, S_M_PCHK, S_M_WIDX, S_P_RD, S_P_WR, S_DONE
   } state_type;

   localparam int IW = ffpa_pkg::IDX_W;
   localparam int PW = ffpa_pkg::PTR_W;
   localparam int CW = ffpa_pkg::CNT_W;
   localparam int AW = ffpa_pkg::ADDR_W;
   localparam int PAGE_LOW = ffpa_pkg::PAGE_SHIFT;

   state_type            state_ff, ret_ff;
   logic [IW-1:0]        clr_ff;
   logic [1:0]           op_ff;
   logic [CW-1:0]        n_ff;
   logic [AW-1:0]        a_ff;
   logic [PW-1:0]        cur_ff, idx_ff, nw_ff, p_addr_ff, p_val_ff;
   logic [CW-1:0]        e_len_ff;
   logic [PW-1:0]        e_next_ff, e_prev_ff;
   logic [2:0]           st_ff;
   logic [AW-1:0]        addr_ff;
   logic                 inr_ff;
   logic                 rsp_valid_ff;
   ffpa_pkg::rsp_type    rsp_ff;

   logic                 hit, split, nw_ok;
   logic [CW:0]          nw_sum;
   logic [AW-1:0]        cur_addr;
   logic [AW-1:0]        off;
   logic [AW-PAGE_LOW-1:0] page;
   logic                 pg_in;
   logic [2:0]           chk_st;
   ffpa_pkg::entry_type  wd;

   assign hit    = (q.refc == '0) && (q.len >= n_ff);
   assign split  = q.len > n_ff;
   assign nw_sum = (CW+1)'(cur_ff) + (CW+1)'(n_ff);
   assign nw_ok  = 32'(nw_sum) < ffpa_pkg::MAX_PAGES;
   assign cur_addr = cfg.base_addr + (AW'(cur_ff[IW-1:0]) << PAGE_LOW);

   // Address decode for share, free and query
   assign off   = req_data.phys_addr - cfg.base_addr;
   assign page  = off[AW-1:PAGE_LOW];
   assign pg_in = 32'(page) < 32'(cfg.num_pages);

   always_comb begin
      if ((req_data.phys_addr & ffpa_pkg::PAGE_MASK) != '0) begin
         chk_st = ffpa_pkg::ST_MISALIGN;
      end else if (req_data.phys_addr < cfg.base_addr) begin
         chk_st = ffpa_pkg::ST_BELOW;
      end else if (!pg_in) begin
         chk_st = ffpa_pkg::ST_ABOVE;
      end else begin
         chk_st = ffpa_pkg::ST_OK;
      end
   end

   always_comb begin
      mem = '0;
      wd  = q;
      unique case (state_ff)
         S_CLEAR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = clr_ff;
            wd.len  = (clr_ff == '0) ? cfg.num_pages : '0;
            wd.refc = '0;
            wd.next = ffpa_pkg::NULL_PTR;
            wd.prev = ffpa_pkg::NULL_PTR;
         end
         S_A_RD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = cur_ff[IW-1:0];
         end
         S_A_CHK: begin
            if (hit && split && nw_ok) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = nw_sum[IW-1:0];
               wd.len  = q.len - n_ff;
               wd.refc = '0;
               wd.next = q.next;
               wd.prev = cur_ff;
            end else if (hit && !split) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = cur_ff[IW-1:0];
               wd.refc = ffpa_pkg::REF_BITS'(1);
            end
         end
         S_A_CUR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = cur_ff[IW-1:0];
            wd.len  = n_ff;
            wd.refc = ffpa_pkg::REF_BITS'(1);
            wd.next = nw_ff;
            wd.prev = e_prev_ff;
         end
         S_F_RD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = idx_ff[IW-1:0];
         end
         S_F_CHK: begin
            if (q.refc != '0) begin
               if (op_ff == ffpa_pkg::OP_SHARE) begin
                  mem.wr_en   = 1'b1;
                  mem.wr_addr = idx_ff[IW-1:0];
                  if (q.refc != ffpa_pkg::REF_MAX) begin
                     wd.refc = q.refc + 1'b1;
                  end
               end else if (q.refc > ffpa_pkg::REF_BITS'(1)) begin
                  mem.wr_en   = 1'b1;
                  mem.wr_addr = idx_ff[IW-1:0];
                  wd.refc = q.refc - 1'b1;
               end
            end
         end
         S_M_NRD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = e_next_ff[IW-1:0];
         end
         S_M_P: begin
            mem.rd_en   = e_prev_ff < ffpa_pkg::NULL_PTR;
            mem.rd_addr = e_prev_ff[IW-1:0];
         end
         S_M_PCHK: begin
            if (q.refc == '0) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = e_prev_ff[IW-1:0];
               wd.len  = q.len + e_len_ff;
               wd.next = e_next_ff;
            end
         end
         S_M_WIDX: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_ff[IW-1:0];
            wd.len  = e_len_ff;
            wd.refc = '0;
            wd.next = e_next_ff;
            wd.prev = e_prev_ff;
         end
         S_P_RD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = p_addr_ff[IW-1:0];
         end
         S_P_WR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = p_addr_ff[IW-1:0];
            wd.prev = p_val_ff;
         end
         default: ;
      endcase
      mem.wr_data = wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_DONE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.reinit) begin
            state_ff <= S_CLEAR;
            clr_ff   <= '0;
         end else begin
            unique case (state_ff)
               S_CLEAR: begin
                  clr_ff <= clr_ff + 1'b1;
                  if (clr_ff == IW'(ffpa_pkg::MAX_PAGES - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_valid) begin
                     op_ff   <= req_data.op;
                     n_ff    <= req_data.page_count;
                     a_ff    <= req_data.phys_addr;
                     cur_ff  <= '0;
                     idx_ff  <= PW'(page[IW-1:0]);
                     st_ff   <= ffpa_pkg::ST_OK;
                     addr_ff <= '0;
                     inr_ff  <= 1'b0;
                     case (req_data.op)
                        ffpa_pkg::OP_ALLOC: begin
                           if (req_data.page_count == '0) begin
                              st_ff    <= ffpa_pkg::ST_NOFIT;
                              state_ff <= S_DONE;
                           end else begin
                              state_ff <= S_A_RD;
                           end
                        end
                        ffpa_pkg::OP_QUERY: begin
                           addr_ff  <= req_data.phys_addr;
                           inr_ff   <= (req_data.phys_addr >= cfg.base_addr) && pg_in;
                           state_ff <= S_DONE;
                        end
                        default: begin
                           if (chk_st != ffpa_pkg::ST_OK) begin
                              st_ff    <= chk_st;
                              state_ff <= S_DONE;
                           end else begin
                              state_ff <= S_F_RD;
                           end
                        end
                     endcase
                  end
               end
               S_A_RD: state_ff <= S_A_CHK;
               S_A_CHK: begin
                  if (hit) begin
                     if (split) begin
                        if (nw_ok) begin
                           nw_ff     <= PW'(nw_sum);
                           e_prev_ff <= q.prev;
                           p_addr_ff <= q.next;
                           p_val_ff  <= PW'(nw_sum);
                           state_ff  <= S_A_CUR;
                        end else begin
                           st_ff    <= ffpa_pkg::ST_NOFIT;
                           state_ff <= S_DONE;
                        end
                     end else begin
                        addr_ff  <= cur_addr;
                        state_ff <= S_DONE;
                     end
                  end else begin
                     cur_ff <= q.next;
                     if (32'(q.next) < 32'(cfg.num_pages)) begin
                        state_ff <= S_A_RD;
                     end else begin
                        st_ff    <= ffpa_pkg::ST_NOFIT;
                        state_ff <= S_DONE;
                     end
                  end
               end
               S_A_CUR: begin
                  addr_ff <= cur_addr;
                  if (p_addr_ff < ffpa_pkg::NULL_PTR) begin
                     ret_ff   <= S_DONE;
                     state_ff <= S_P_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
               S_F_RD: state_ff <= S_F_CHK;
               S_F_CHK: begin
                  e_len_ff  <= q.len;
                  e_next_ff <= q.next;
                  e_prev_ff <= q.prev;
                  if (q.refc == '0) begin
                     st_ff    <= ffpa_pkg::ST_FREE;
                     state_ff <= S_DONE;
                  end else begin
                     addr_ff <= a_ff;
                     if (op_ff == ffpa_pkg::OP_SHARE || q.refc > ffpa_pkg::REF_BITS'(1)) begin
                        state_ff <= S_DONE;
                     end else if (q.next < ffpa_pkg::NULL_PTR) begin
                        state_ff <= S_M_NRD;
                     end else begin
                        state_ff <= S_M_P;
                     end
                  end
               end
               S_M_NRD: state_ff <= S_M_NCHK;
               S_M_NCHK: begin
                  state_ff <= S_M_P;
                  if (q.refc == '0) begin
                     // absorb the free block that follows
                     e_len_ff  <= e_len_ff + q.len;
                     e_next_ff <= q.next;
                     if (q.next < ffpa_pkg::NULL_PTR) begin
                        p_addr_ff <= q.next;
                        p_val_ff  <= idx_ff;
                        ret_ff    <= S_M_P;
                        state_ff  <= S_P_RD;
                     end
                  end
               end
               S_M_P: begin
                  state_ff <= (e_prev_ff < ffpa_pkg::NULL_PTR) ? S_M_PCHK : S_M_WIDX;
               end
               S_M_PCHK: begin
                  state_ff <= S_M_WIDX;
                  if (q.refc == '0 && e_next_ff < ffpa_pkg::NULL_PTR) begin
                     p_addr_ff <= e_next_ff;
                     p_val_ff  <= e_prev_ff;
                     ret_ff    <= S_M_WIDX;
                     state_ff  <= S_P_RD;
                  end
               end
               S_M_WIDX: state_ff <= S_DONE;
               S_P_RD:   state_ff <= S_P_WR;
               S_P_WR:   state_ff <= ret_ff;
               S_DONE: begin
                  // hold until the output register is free
                  if (!rsp_valid_ff) begin
                     rsp_ff.status      <= st_ff;
                     rsp_ff.result_addr <= addr_ff;
                     rsp_ff.in_range    <= inr_ff;
                     rsp_valid_ff       <= 1'b1;
                     state_ff           <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

/* rtl/first_fit_page_allocator.sv */
// First-fit page allocator: keeps the managed pages as an address-ordered list of
// blocks in one single-port-read, single-port-write table RAM, one entry per page.
// Every item gives exactly one result. Queries are answered without a table read.
// Allocate reads one block at a time as it walks the list, then splits and
// relinks; add reference reads and rewrites one entry; the last free merges
// with its free neighbours. A result still waiting in the output register holds the
// engine in its last state until the receiver takes it. After reset and after every
// register write every table entry is cleared, one entry a cycle, and no item is
// accepted in that time.
`default_nettype none
module first_fit_page_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffpa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffpa_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);
   ffpa_pkg::cfg_type     cfg;
   ffpa_pkg::mem_req_type mem;
   logic [ffpa_pkg::ENTRY_W-1:0] rd_data;

   ffpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ffpa_ram #(
      .WIDTH (ffpa_pkg::ENTRY_W),
      .DEPTH (ffpa_pkg::MAX_PAGES)
   ) u_table (
      .clock   (clock),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data)
   );

   ffpa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem       (mem),
      .q         (ffpa_pkg::entry_type'(rd_data))
   );
endmodule
`default_nettype wire

/* rtl/ffpa_checker.sv */
`default_nettype none
module ffpa_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ffpa_pkg::rsp_type rsp_data,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic              pready
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ffpa_pkg::ST_FREE)
      else $error("status code out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ffpa_pkg::ST_OK |->
         rsp_data.result_addr == '0 && !rsp_data.in_range)
      else $error("failed item carries address or range flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_cfg_sweep: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready |=> !req_ready)
      else $error("item taken during table sweep");
endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (.*);
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 6000000;

   localparam int MAX_PAGES  = ffpa_pkg::MAX_PAGES;
   localparam int PAGE_SHIFT = ffpa_pkg::PAGE_SHIFT;
   localparam int REF_BITS   = ffpa_pkg::REF_BITS;
   localparam int CNT_W      = ffpa_pkg::CNT_W;
   localparam int PTR_W      = ffpa_pkg::PTR_W;

   localparam logic [PTR_W-1:0]    NULL_PTR  = ffpa_pkg::NULL_PTR;
   localparam logic [REF_BITS-1:0] REF_MAX   = ffpa_pkg::REF_MAX;
   localparam logic [31:0]         PAGE_MASK = ffpa_pkg::PAGE_MASK;

   localparam logic [1:0] OP_ALLOC = ffpa_pkg::OP_ALLOC;
   localparam logic [1:0] OP_SHARE = ffpa_pkg::OP_SHARE;
   localparam logic [1:0] OP_FREE  = ffpa_pkg::OP_FREE;
   localparam logic [1:0] OP_QUERY = ffpa_pkg::OP_QUERY;

   localparam logic [2:0] ST_OK       = ffpa_pkg::ST_OK;
   localparam logic [2:0] ST_NOFIT    = ffpa_pkg::ST_NOFIT;
   localparam logic [2:0] ST_MISALIGN = ffpa_pkg::ST_MISALIGN;
   localparam logic [2:0] ST_BELOW    = ffpa_pkg::ST_BELOW;
   localparam logic [2:0] ST_ABOVE    = ffpa_pkg::ST_ABOVE;
   localparam logic [2:0] ST_FREE     = ffpa_pkg::ST_FREE;

   localparam logic REG_BASE = ffpa_pkg::REG_BASE;
   localparam logic REG_NUM  = ffpa_pkg::REG_NUM;

   typedef ffpa_pkg::req_type req_type;
   typedef ffpa_pkg::rsp_type rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   first_fit_page_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // shadow of the page tables
   logic [CNT_W-1:0]    pg_len [MAX_PAGES];
   logic [REF_BITS-1:0] pg_ref [MAX_PAGES];
   logic [PTR_W-1:0]    pg_nxt [MAX_PAGES];
   logic [PTR_W-1:0]    pg_prv [MAX_PAGES];
   logic [31:0]         cfg_base;
   int                  cfg_pages;

   rsp_type awaited_rsp[$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      rsp_checked = 0;
   int      csr_writes = 0;
   int      cycles = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void clear_pages();
      for (int i = 0; i < MAX_PAGES; i++) begin
         pg_len[i] = '0;
         pg_ref[i] = '0;
         pg_nxt[i] = NULL_PTR;
         pg_prv[i] = NULL_PTR;
      end
      pg_len[0] = CNT_W'(cfg_pages);
   endfunction

   // 0 ok, else status; page index returned through idx
   function automatic logic [2:0] locate_page(input logic [31:0] a, output int idx);
      logic [31:0] off;
      idx = 0;
      if ((a & PAGE_MASK) != 0) return ST_MISALIGN;
      if (a < cfg_base) return ST_BELOW;
      off = (a - cfg_base) >> PAGE_SHIFT;
      if (off >= 32'(cfg_pages)) return ST_ABOVE;
      idx = int'(off);
      return ST_OK;
   endfunction

   function automatic rsp_type allocator_outcome(input req_type r);
      rsp_type     o;
      int          cur, steps, nw, nx, nn, pv, idx, n;
      logic [31:0] off;
      o = '0;
      n = int'(r.page_count);
      case (r.op)
         OP_ALLOC: begin
            o.status = ST_NOFIT;
            cur = 0;
            steps = 0;
            if (n != 0) begin
               while (cur < cfg_pages && cur < MAX_PAGES && steps < MAX_PAGES) begin
                  steps++;
                  if (pg_ref[cur] == 0 && int'(pg_len[cur]) >= n) begin
                     if (int'(pg_len[cur]) > n) begin
                        nw = cur + n;
                        if (nw >= MAX_PAGES) break;
                        nx = int'(pg_nxt[cur]);
                        pg_len[nw] = pg_len[cur] - CNT_W'(n);
                        pg_ref[nw] = '0;
                        pg_prv[nw] = PTR_W'(cur);
                        pg_nxt[nw] = PTR_W'(nx);
                        if (nx < MAX_PAGES) pg_prv[nx] = PTR_W'(nw);
                        pg_len[cur] = CNT_W'(n);
                        pg_nxt[cur] = PTR_W'(nw);
                     end
                     pg_ref[cur] = 1;
                     o.status = ST_OK;
                     o.result_addr = cfg_base + (32'(cur) << PAGE_SHIFT);
                     break;
                  end
                  cur = int'(pg_nxt[cur]);
               end
            end
         end
         OP_SHARE, OP_FREE: begin
            o.status = locate_page(r.phys_addr, idx);
            if (o.status == ST_OK && pg_ref[idx] == 0) o.status = ST_FREE;
            if (o.status == ST_OK) begin
               o.result_addr = r.phys_addr;
               if (r.op == OP_SHARE) begin
                  if (pg_ref[idx] != REF_MAX) pg_ref[idx]++;
               end else if (pg_ref[idx] > 1) begin
                  pg_ref[idx]--;
               end else begin
                  // merge with a free follower, then with a free predecessor
                  nx = int'(pg_nxt[idx]);
                  if (nx < MAX_PAGES && pg_ref[nx] == 0) begin
                     nn = int'(pg_nxt[nx]);
                     pg_len[idx] += pg_len[nx];
                     pg_nxt[idx] = PTR_W'(nn);
                     if (nn < MAX_PAGES) pg_prv[nn] = PTR_W'(idx);
                  end
                  pv = int'(pg_prv[idx]);
                  if (pv < MAX_PAGES && pg_ref[pv] == 0) begin
                     nn = int'(pg_nxt[idx]);
                     pg_len[pv] += pg_len[idx];
                     pg_nxt[pv] = PTR_W'(nn);
                     if (nn < MAX_PAGES) pg_prv[nn] = PTR_W'(pv);
                  end
                  pg_ref[idx] = '0;
               end
            end
         end
         default: begin
            o.result_addr = r.phys_addr;
            off = (r.phys_addr - cfg_base) >> PAGE_SHIFT;
            o.in_range = (r.phys_addr >= cfg_base) && (off < 32'(cfg_pages));
         end
      endcase
      return o;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_rsp.size());
         $display("first_fit_page_allocator regression: fail");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected item %h", rsp_data));
         end else begin
            want = awaited_rsp.pop_front();
            rsp_checked++;
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.result_addr !== want.result_addr)
               report_mismatch($sformatf("result_addr %h, want %h",
                                         rsp_data.result_addr, want.result_addr));
            if (rsp_data.in_range !== want.in_range)
               report_mismatch($sformatf("in_range %b, want %b",
                                         rsp_data.in_range, want.in_range));
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   task automatic send_item(input logic [1:0] op, input int cnt, input logic [31:0] a);
      req_type r;
      int      gap;
      r.op = op;
      r.page_count = CNT_W'(cnt);
      r.phys_addr = a;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      awaited_rsp.push_back(allocator_outcome(r));
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (awaited_rsp.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_sel, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (reg_sel == REG_BASE) begin
         cfg_base = value & ~PAGE_MASK;
      end else begin
         cfg_pages = int'(value[CNT_W-1:0]);
         if (cfg_pages == 0) cfg_pages = 1;
         if (cfg_pages > MAX_PAGES) cfg_pages = MAX_PAGES;
      end
      clear_pages();
      csr_writes++;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] page_at(input int idx);
      return cfg_base + (32'(idx) << PAGE_SHIFT);
   endfunction

   // address of some used block start, or a random address when none is held
   function automatic logic [31:0] pick_used();
      int s;
      s = $urandom_range(0, cfg_pages - 1);
      for (int k = 0; k < cfg_pages; k++)
         if (pg_ref[(s + k) % cfg_pages] != 0) return page_at((s + k) % cfg_pages);
      return $urandom();
   endfunction

   task automatic test_whole_store();
      // default setting: take all pages in one go, then hand them back
      send_item(OP_ALLOC, MAX_PAGES, 32'h0);
      send_item(OP_ALLOC, 1, 32'h0);
      send_item(OP_FREE, 0, 32'h0);
      send_item(OP_ALLOC, 2047, 32'h0);
      send_item(OP_QUERY, 0, 32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_directed_cases();
      write_csr(REG_BASE, 32'h1000_0ABC);
      write_csr(REG_NUM, 32'd16);
      send_item(OP_ALLOC, 0, 32'h0);
      send_item(OP_ALLOC, 4, 32'h0);
      send_item(OP_ALLOC, 4, 32'h0);
      send_item(OP_ALLOC, 8, 32'h0);
      send_item(OP_ALLOC, 1, 32'h0);
      send_item(OP_SHARE, 0, page_at(0));
      send_item(OP_FREE, 0, page_at(0));
      send_item(OP_FREE, 0, page_at(0));
      send_item(OP_FREE, 0, page_at(8));
      send_item(OP_FREE, 0, page_at(4));
      send_item(OP_FREE, 0, page_at(0) + 1);
      send_item(OP_FREE, 0, cfg_base - 32'h1000);
      send_item(OP_SHARE, 0, page_at(16));
      send_item(OP_SHARE, 0, page_at(0));
      send_item(OP_ALLOC, 2, 32'h0);
      send_item(OP_SHARE, 0, page_at(1));
      send_item(OP_QUERY, 0, cfg_base - 1);
      send_item(OP_QUERY, 0, cfg_base);
      send_item(OP_QUERY, 0, page_at(16) - 1);
      send_item(OP_QUERY, 0, page_at(16));
      drain();
      // range wrapping past the top of the address space
      write_csr(REG_BASE, 32'hFFFF_F000);
      write_csr(REG_NUM, 32'd4);
      send_item(OP_ALLOC, 1, 32'h0);
      send_item(OP_ALLOC, 2, 32'h0);
      send_item(OP_QUERY, 0, 32'h0000_0000);
      send_item(OP_FREE, 0, 32'h0000_0000);
      drain();
   endtask

   task automatic test_ref_counting();
      // raise the count, then release it down to zero and past it
      write_csr(REG_BASE, 32'h0);
      write_csr(REG_NUM, 32'd0);
      send_item(OP_ALLOC, 1, 32'h0);
      for (int i = 0; i < 20; i++) send_item(OP_SHARE, 0, 32'h0);
      for (int i = 0; i < 22; i++) send_item(OP_FREE, 0, 32'h0);
      send_item(OP_SHARE, 0, 32'h0);
      send_item(OP_SHARE, 0, 32'h0);
      drain();
   endtask

   task automatic test_random_traffic(input logic [31:0] base, input int pages,
                                      input int idle_pct, input int stall_pct,
                                      input int count);
      int          sel, cnt;
      logic [31:0] a;
      write_csr(REG_BASE, base);
      write_csr(REG_NUM, 32'(pages));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         cnt = $urandom_range(1, 8);
         a = $urandom();
         if (sel < 35) begin
            if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 2047);
            else if ($urandom_range(0, 19) == 0) cnt = $urandom_range(1, cfg_pages);
            send_item(OP_ALLOC, cnt, a);
         end else if (sel < 55) begin
            send_item(OP_FREE, $urandom_range(0, 2047), pick_used());
         end else if (sel < 68) begin
            send_item(OP_SHARE, $urandom_range(0, 2047), pick_used());
         end else if (sel < 82) begin
            if ($urandom_range(0, 1)) a = cfg_base + $urandom_range(0, (cfg_pages + 2) << 12) - 32'h800;
            send_item(OP_QUERY, $urandom_range(0, 2047), a);
         end else begin
            // noise: off-range, misaligned, inside blocks
            if ($urandom_range(0, 1)) a = page_at($urandom_range(0, cfg_pages + 1))
                                          + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4095) : 0);
            send_item(2'($urandom_range(1, 2)), $urandom_range(0, 2047), a);
         end
      end
      drain();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      cfg_base = '0;
      cfg_pages = MAX_PAGES;
      clear_pages();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_whole_store();
      test_directed_cases();
      test_ref_counting();
      test_random_traffic(32'h0,         MAX_PAGES, 0,  0,  120);
      test_random_traffic(32'h8000_0000, 32,        84, 0,  130);
      test_random_traffic(32'hFFFF_0000, 2047,      0,  84, 130);
      test_random_traffic($urandom(),    $urandom_range(1, 64), 25, 25, 130);
      test_random_traffic(32'hFFFF_FFFF, 3,         0,  0,  130);

      $display("covered %0d items, %0d results checked, %0d register writes",
               items_sent, rsp_checked, csr_writes);
      $display("alloc, share, free and query under sender gaps and receiver stalls");
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("first_fit_page_allocator regression: pass");
      end else begin
         $display("first_fit_page_allocator regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/ffpa_csr.sv
rtl/ffpa_engine.sv
rtl/first_fit_page_allocator.sv
rtl/ffpa_checker.sv
bench/tb.sv
